FILE: hw/rtl/livc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// livc_pkg
// Shared sizes, register indexes, opcodes and types of the interior voxel
// clearing block.
// ----------------------------------------------------------------------------
package livc_pkg;

   localparam int MAX_X      = 256;
   localparam int MAX_Y      = 256;
   localparam int LABEL_BITS = 16;

   // Width of the label ports on the word channels.
   localparam int VOXEL_W = 16;
   // Labels are cut to the port width and then to LABEL_BITS.
   localparam int LBL_W   = (LABEL_BITS < VOXEL_W) ? LABEL_BITS : VOXEL_W;

   // History ring: two planes and one row at the largest volume size.
   localparam int HIST_DEPTH = 2 * MAX_X * MAX_Y + MAX_X;
   localparam int ADDR_W     = $clog2(HIST_DEPTH);

   localparam int CSR_SX_W   = 9;
   localparam int CSR_SY_W   = 9;
   localparam int CSR_SZ_W   = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;

   localparam int SX_W    = $clog2(MAX_X + 1);
   localparam int SY_W    = $clog2(MAX_Y + 1);
   localparam int SZ_W    = CSR_SZ_W;
   localparam int X_W     = $clog2(MAX_X);
   localparam int Y_W     = $clog2(MAX_Y);
   localparam int Z_W     = SZ_W;
   localparam int PLANE_W = $clog2(MAX_X * MAX_Y + 1);
   localparam int LAG_W   = $clog2(MAX_X * MAX_Y + MAX_X + 1);
   localparam int POS_W   = PLANE_W + SZ_W;

   localparam logic [CSR_IDX_W-1:0] REG_SIZE_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SIZE_Z = CSR_IDX_W'(2);

   localparam logic OP_PUSH  = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   localparam int RST_SIZE  = 256;
   localparam int RST_SX    = (RST_SIZE > MAX_X) ? MAX_X : RST_SIZE;
   localparam int RST_SY    = (RST_SIZE > MAX_Y) ? MAX_Y : RST_SIZE;
   localparam int RST_SZ    = RST_SIZE;
   localparam int RST_PLANE = RST_SX * RST_SY;
   localparam int RST_LAG   = RST_PLANE + RST_SX;

   // Memory traffic of one accepted word: one write, six reads (the center and five neighbors).
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [LBL_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_center;
      logic [ADDR_W-1:0] rd_right;
      logic [ADDR_W-1:0] rd_row_prev;
      logic [ADDR_W-1:0] rd_row_next;
      logic [ADDR_W-1:0] rd_plane_prev;
      logic [ADDR_W-1:0] rd_plane_next;
   } hist_access_type;

   // Facts about the voxel being released, known before its labels are read.
   typedef struct packed {
      logic valid;
      logic interior;
      logic has_right;
      logic has_row_next;
      logic has_plane_next;
      logic last;
   } issue_type;

   function automatic logic [SX_W-1:0] clamp_sx(input logic [CSR_SX_W-1:0] v);
      if (v == '0) begin
         return SX_W'(1);
      end
      if (32'(v) > MAX_X) begin
         return SX_W'(MAX_X);
      end
      return SX_W'(v);
   endfunction

   function automatic logic [SY_W-1:0] clamp_sy(input logic [CSR_SY_W-1:0] v);
      if (v == '0) begin
         return SY_W'(1);
      end
      if (32'(v) > MAX_Y) begin
         return SY_W'(MAX_Y);
      end
      return SY_W'(v);
   endfunction

   function automatic logic [SZ_W-1:0] clamp_sz(input logic [CSR_SZ_W-1:0] v);
      if (v == '0) begin
         return SZ_W'(1);
      end
      return SZ_W'(v);
   endfunction

endpackage

FILE: hw/rtl/livc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// livc_ram
// Generic synchronous RAM: one write port, two read ports with registered
// read data. A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module livc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a_ff <= mem_ff[rd_addr_a];
         rd_data_b_ff <= mem_ff[rd_addr_b];
      end
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

FILE: hw/rtl/livc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// livc_ctrl
// Input side and sequencing: size registers, input and output positions,
// ring pointers and the neighbor addresses of the voxel being released.
// ----------------------------------------------------------------------------
module livc_ctrl
   import livc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [VOXEL_W-1:0]    req_voxel_label,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output hist_access_type       hist,
   output issue_type             issue
);

   localparam int SUM_W = ADDR_W + 1;
   localparam int ZC_W  = SZ_W + 1;

   logic [SX_W-1:0]    sx_ff,    sx_in;
   logic [SY_W-1:0]    sy_ff,    sy_in;
   logic [SZ_W-1:0]    sz_ff,    sz_in;
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic [LAG_W-1:0]   lag_ff,   lag_in;

   logic [X_W-1:0]     in_x_ff,  in_x_in;
   logic [Y_W-1:0]     in_y_ff,  in_y_in;
   logic [Z_W-1:0]     in_z_ff,  in_z_in;
   logic               in_full_ff, in_full_in;
   logic [ADDR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [X_W-1:0]     out_x_ff, out_x_in;
   logic [Y_W-1:0]     out_y_ff, out_y_in;
   logic [Z_W-1:0]     out_z_ff, out_z_in;
   logic [ADDR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [POS_W-1:0]   pend_ff,  pend_in;

   logic               cfg_hit;
   logic               accept;
   logic               push_write;
   logic               do_emit;
   logic               in_last;
   logic               out_last;
   logic               restart;
   logic [SX_W-1:0]    sx_last;
   logic [SY_W-1:0]    sy_last;
   logic [SZ_W-1:0]    sz_last;
   logic               inner_x;
   logic               inner_y;
   logic               inner_z;

   function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0]  ptr,
                                                  input logic [PLANE_W-1:0] off);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(ptr) + SUM_W'(off);
      if (sum >= SUM_W'(HIST_DEPTH)) begin
         sum = sum - SUM_W'(HIST_DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] ring_sub(input logic [ADDR_W-1:0]  ptr,
                                                  input logic [PLANE_W-1:0] off);
      logic [SUM_W-1:0] dif;
      if (SUM_W'(ptr) >= SUM_W'(off)) begin
         dif = SUM_W'(ptr) - SUM_W'(off);
      end else begin
         dif = SUM_W'(ptr) + SUM_W'(HIST_DEPTH) - SUM_W'(off);
      end
      return dif[ADDR_W-1:0];
   endfunction

   // Size registers. Plane and lag follow every size write at the same edge.
   always_comb begin
      sx_in   = sx_ff;
      sy_in   = sy_ff;
      sz_in   = sz_ff;
      cfg_hit = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_SIZE_X: begin
               sx_in   = clamp_sx(csr_wr_data[CSR_SX_W-1:0]);
               cfg_hit = 1'b1;
            end
            REG_SIZE_Y: begin
               sy_in   = clamp_sy(csr_wr_data[CSR_SY_W-1:0]);
               cfg_hit = 1'b1;
            end
            REG_SIZE_Z: begin
               sz_in   = clamp_sz(csr_wr_data[CSR_SZ_W-1:0]);
               cfg_hit = 1'b1;
            end
            default: begin
            end
         endcase
      end
      plane_in = PLANE_W'(sx_in) * PLANE_W'(sy_in);
      lag_in   = LAG_W'(plane_in) + LAG_W'(sx_in);
   end

   assign sx_last = sx_ff - SX_W'(1);
   assign sy_last = sy_ff - SY_W'(1);
   assign sz_last = sz_ff - SZ_W'(1);

   assign accept     = req_valid & ~req_stall;
   assign push_write = accept & (req_opcode == OP_PUSH) & ~in_full_ff;

   // A push releases the oldest voxel once a full plane and row are pending;
   // a drain releases it whenever anything is pending.
   always_comb begin
      if (req_opcode == OP_PUSH) begin
         do_emit = accept & ~in_full_ff & (pend_ff >= POS_W'(lag_ff));
      end else begin
         do_emit = accept & (pend_ff != '0);
      end
   end

   assign in_last  = (SX_W'(in_x_ff) == sx_last) && (SY_W'(in_y_ff) == sy_last) &&
                     (in_z_ff == sz_last);
   assign out_last = (SX_W'(out_x_ff) == sx_last) && (SY_W'(out_y_ff) == sy_last) &&
                     (out_z_ff == sz_last);
   assign restart  = cfg_hit | (do_emit & out_last);

   always_comb begin
      in_x_in    = in_x_ff;
      in_y_in    = in_y_ff;
      in_z_in    = in_z_ff;
      in_full_in = in_full_ff;
      wr_ptr_in  = wr_ptr_ff;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      out_z_in   = out_z_ff;
      rd_ptr_in  = rd_ptr_ff;
      pend_in    = pend_ff;
      if (restart) begin
         in_x_in    = '0;
         in_y_in    = '0;
         in_z_in    = '0;
         in_full_in = 1'b0;
         wr_ptr_in  = '0;
         out_x_in   = '0;
         out_y_in   = '0;
         out_z_in   = '0;
         rd_ptr_in  = '0;
         pend_in    = '0;
      end else begin
         if (push_write) begin
            wr_ptr_in = (wr_ptr_ff == ADDR_W'(HIST_DEPTH - 1)) ? '0 :
                        wr_ptr_ff + ADDR_W'(1);
            if (in_last) begin
               in_full_in = 1'b1;
            end
            if (SX_W'(in_x_ff) == sx_last) begin
               in_x_in = '0;
               if (SY_W'(in_y_ff) == sy_last) begin
                  in_y_in = '0;
                  in_z_in = in_z_ff + Z_W'(1);
               end else begin
                  in_y_in = in_y_ff + Y_W'(1);
               end
            end else begin
               in_x_in = in_x_ff + X_W'(1);
            end
         end
         if (do_emit) begin
            rd_ptr_in = (rd_ptr_ff == ADDR_W'(HIST_DEPTH - 1)) ? '0 :
                        rd_ptr_ff + ADDR_W'(1);
            if (SX_W'(out_x_ff) == sx_last) begin
               out_x_in = '0;
               if (SY_W'(out_y_ff) == sy_last) begin
                  out_y_in = '0;
                  out_z_in = out_z_ff + Z_W'(1);
               end else begin
                  out_y_in = out_y_ff + Y_W'(1);
               end
            end else begin
               out_x_in = out_x_ff + X_W'(1);
            end
         end
         unique case ({push_write, do_emit})
            2'b10:   pend_in = pend_ff + POS_W'(1);
            2'b01:   pend_in = pend_ff - POS_W'(1);
            default: pend_in = pend_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sx_ff      <= SX_W'(RST_SX);
         sy_ff      <= SY_W'(RST_SY);
         sz_ff      <= SZ_W'(RST_SZ);
         plane_ff   <= PLANE_W'(RST_PLANE);
         lag_ff     <= LAG_W'(RST_LAG);
         in_x_ff    <= '0;
         in_y_ff    <= '0;
         in_z_ff    <= '0;
         in_full_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
         out_z_ff   <= '0;
         rd_ptr_ff  <= '0;
         pend_ff    <= '0;
      end else begin
         sx_ff      <= sx_in;
         sy_ff      <= sy_in;
         sz_ff      <= sz_in;
         plane_ff   <= plane_in;
         lag_ff     <= lag_in;
         in_x_ff    <= in_x_in;
         in_y_ff    <= in_y_in;
         in_z_ff    <= in_z_in;
         in_full_ff <= in_full_in;
         wr_ptr_ff  <= wr_ptr_in;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         out_z_ff   <= out_z_in;
         rd_ptr_ff  <= rd_ptr_in;
         pend_ff    <= pend_in;
      end
   end

   assign inner_x = (out_x_ff != '0) && ((SX_W'(out_x_ff) + SX_W'(1)) < sx_ff);
   assign inner_y = (out_y_ff != '0) && ((SY_W'(out_y_ff) + SY_W'(1)) < sy_ff);
   assign inner_z = (out_z_ff != '0) && ((ZC_W'(out_z_ff) + ZC_W'(1)) < ZC_W'(sz_ff));

   // The memories read before they write, so a slot that is reused by this
   // very push still shows the neighbor one plane back.
   always_comb begin
      hist.wr_en         = push_write;
      hist.wr_addr       = wr_ptr_ff;
      hist.wr_data       = req_voxel_label[LBL_W-1:0];
      hist.rd_en         = do_emit;
      hist.rd_center     = rd_ptr_ff;
      hist.rd_right      = ring_add(rd_ptr_ff, PLANE_W'(1));
      hist.rd_row_prev   = ring_sub(rd_ptr_ff, PLANE_W'(sx_ff));
      hist.rd_row_next   = ring_add(rd_ptr_ff, PLANE_W'(sx_ff));
      hist.rd_plane_prev = ring_sub(rd_ptr_ff, plane_ff);
      hist.rd_plane_next = ring_add(rd_ptr_ff, plane_ff);
   end

   // Neighbors ahead of the released voxel count only if already received.
   always_comb begin
      issue.valid          = do_emit;
      issue.interior       = inner_x & inner_y & inner_z;
      issue.has_right      = pend_ff > POS_W'(1);
      issue.has_row_next   = pend_ff > POS_W'(sx_ff);
      issue.has_plane_next = pend_ff > POS_W'(plane_ff);
      issue.last           = out_last;
   end

endmodule

FILE: hw/rtl/livc_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// livc_cmp
// Neighbor compare stage and result register. Clears a released voxel when
// it is interior and all six face neighbors carry its label.
// ----------------------------------------------------------------------------
module livc_cmp
   import livc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  issue_type          issue,
   input  logic [LBL_W-1:0]   center,
   input  logic [LBL_W-1:0]   right,
   input  logic [LBL_W-1:0]   row_prev,
   input  logic [LBL_W-1:0]   row_next,
   input  logic [LBL_W-1:0]   plane_prev,
   input  logic [LBL_W-1:0]   plane_next,
   input  logic               rsp_stall,
   output logic               stage_stall,
   output logic               rsp_valid,
   output logic [VOXEL_W-1:0] rsp_label_out,
   output logic               rsp_last_voxel
);

   logic               s1_valid_ff, s1_valid_in;
   issue_type          s1_ff;
   logic [LBL_W-1:0]   left_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VOXEL_W-1:0] rsp_label_ff;
   logic               rsp_last_ff;
   logic               s1_adv;
   logic               s1_move;
   logic               same_all;
   logic [LBL_W-1:0]   label_res;

   assign s1_adv      = ~rsp_valid_ff | ~rsp_stall;
   assign s1_move     = s1_valid_ff & s1_adv;
   assign stage_stall = s1_valid_ff & ~s1_adv;

   // The left neighbor is the center of the previous released voxel.
   assign same_all = (center == left_ff) &&
                     (center == right)      && s1_ff.has_right &&
                     (center == row_prev)   &&
                     (center == row_next)   && s1_ff.has_row_next &&
                     (center == plane_prev) &&
                     (center == plane_next) && s1_ff.has_plane_next;

   assign label_res = (s1_ff.interior && (center != '0) && same_all) ? '0 : center;

   always_comb begin
      if (issue.valid) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_move) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         s1_ff <= issue;
      end
      if (s1_move) begin
         rsp_label_ff <= VOXEL_W'(label_res);
         rsp_last_ff  <= s1_ff.last;
         left_ff      <= center;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_label_out  = rsp_label_ff;
   assign rsp_last_voxel = rsp_last_ff;

endmodule

FILE: hw/rtl/label_interior_voxel_clear_3d.sv
`timescale 1ns / 1ps
// A released voxel passes the compare stage, which takes its memory reads, and then the
// result register that drives rsp. Throughput: one word per cycle while req_stall is low;
// the three two-port history memories read the center and five neighbors at once.
// Results trail the input by one plane plus one row; drain words flush the rest.
// Reset: positions cleared, sizes 256; the history memories are not cleared.
// ----------------------------------------------------------------------------
// label_interior_voxel_clear_3d
// Streams a label volume in raster order and replaces interior voxels whose
// six face neighbors share their label by zero, leaving only label boundaries.
// ----------------------------------------------------------------------------
module label_interior_voxel_clear_3d
   import livc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_opcode,
   input  logic [VOXEL_W-1:0]    req_voxel_label,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VOXEL_W-1:0]    rsp_label_out,
   output logic                  rsp_last_voxel,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   hist_access_type  hist;
   issue_type        issue;
   logic [LBL_W-1:0] center;
   logic [LBL_W-1:0] right;
   logic [LBL_W-1:0] row_prev;
   logic [LBL_W-1:0] row_next;
   logic [LBL_W-1:0] plane_prev;
   logic [LBL_W-1:0] plane_next;

   livc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_voxel_label (req_voxel_label),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data),
      .hist            (hist),
      .issue           (issue)
   );

   // Three copies of the history ring, written alike, two reads each.
   livc_ram #(.WIDTH(LBL_W), .DEPTH(HIST_DEPTH)) u_ram_row (
      .clock     (clock),
      .wr_en     (hist.wr_en),
      .wr_addr   (hist.wr_addr),
      .wr_data   (hist.wr_data),
      .rd_en     (hist.rd_en),
      .rd_addr_a (hist.rd_center),
      .rd_addr_b (hist.rd_right),
      .rd_data_a (center),
      .rd_data_b (right)
   );

   livc_ram #(.WIDTH(LBL_W), .DEPTH(HIST_DEPTH)) u_ram_col (
      .clock     (clock),
      .wr_en     (hist.wr_en),
      .wr_addr   (hist.wr_addr),
      .wr_data   (hist.wr_data),
      .rd_en     (hist.rd_en),
      .rd_addr_a (hist.rd_row_prev),
      .rd_addr_b (hist.rd_row_next),
      .rd_data_a (row_prev),
      .rd_data_b (row_next)
   );

   livc_ram #(.WIDTH(LBL_W), .DEPTH(HIST_DEPTH)) u_ram_plane (
      .clock     (clock),
      .wr_en     (hist.wr_en),
      .wr_addr   (hist.wr_addr),
      .wr_data   (hist.wr_data),
      .rd_en     (hist.rd_en),
      .rd_addr_a (hist.rd_plane_prev),
      .rd_addr_b (hist.rd_plane_next),
      .rd_data_a (plane_prev),
      .rd_data_b (plane_next)
   );

   livc_cmp u_cmp (
      .clock          (clock),
      .reset          (reset),
      .issue          (issue),
      .center         (center),
      .right          (right),
      .row_prev       (row_prev),
      .row_next       (row_next),
      .plane_prev     (plane_prev),
      .plane_next     (plane_next),
      .rsp_stall      (rsp_stall),
      .stage_stall    (req_stall),
      .rsp_valid      (rsp_valid),
      .rsp_label_out  (rsp_label_out),
      .rsp_last_voxel (rsp_last_voxel)
   );

`ifndef SYNTH
   // A voxel is released only by a word that is actually taken.
   a_issue_on_accept: assert property (@(posedge clock) disable iff (reset)
      issue.valid |-> (req_valid && !req_stall))
      else $error("voxel released without an accepted word");

   // The final voxel of a volume is released by a drain, never by a storing push.
   a_last_not_on_write: assert property (@(posedge clock) disable iff (reset)
      hist.wr_en |-> !(issue.valid && issue.last))
      else $error("final voxel released together with a history write");

   // After the final voxel the positions restart, so a push cannot release one.
   a_restart_after_last: assert property (@(posedge clock) disable iff (reset)
      (issue.valid && issue.last) |=> !(issue.valid && (req_opcode == OP_PUSH)))
      else $error("push released a voxel right after the end of a volume");
`endif

endmodule

FILE: tb/label_interior_voxel_clear_3d_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// label_interior_voxel_clear_3d_tb
// Feeds label volumes of many shapes through the interior clearing block and
// checks every output word against a cycle-free predictor of the voxel
// stream. Well-formed volumes dominate; partial and abandoned volumes, early
// and empty drains, and ignored extra pushes are mixed in. Both handshakes
// idle and stall at random in several phases.
// ----------------------------------------------------------------------------
import livc_pkg::*;

localparam logic [CSR_IDX_W-1:0] REG_UNUSED = CSR_IDX_W'(3);
localparam logic [VOXEL_W-1:0]   LABEL_MASK = VOXEL_W'((64'd1 << LBL_W) - 64'd1);

class voxel_scoreboard;
   logic [VOXEL_W-1:0] history [HIST_DEPTH];
   longint             in_pos;
   longint             out_pos;
   longint             dim_x;
   longint             dim_y;
   longint             dim_z;
   logic [VOXEL_W-1:0] want_label [$];
   logic               want_last [$];
   int                 errors;
   int                 words_used;
   int                 results_seen;

   function new();
      dim_x        = RST_SX;
      dim_y        = RST_SY;
      dim_z        = RST_SZ;
      in_pos       = 0;
      out_pos      = 0;
      errors       = 0;
      words_used   = 0;
      results_seen = 0;
   endfunction

   function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      logic [CSR_SX_W-1:0] vx;
      logic [CSR_SY_W-1:0] vy;
      logic [CSR_SZ_W-1:0] vz;
      vx = data[CSR_SX_W-1:0];
      vy = data[CSR_SY_W-1:0];
      vz = data[CSR_SZ_W-1:0];
      case (idx)
         REG_SIZE_X: dim_x = (vx == '0) ? 1 : ((int'(vx) > MAX_X) ? MAX_X : int'(vx));
         REG_SIZE_Y: dim_y = (vy == '0) ? 1 : ((int'(vy) > MAX_Y) ? MAX_Y : int'(vy));
         REG_SIZE_Z: dim_z = (vz == '0) ? 1 : int'(vz);
         default: return;
      endcase
      // Any size write abandons the volume in progress.
      in_pos  = 0;
      out_pos = 0;
   endfunction

   // A neighbor counts only once it has been received.
   function bit holds(longint idx, logic [VOXEL_W-1:0] lab);
      return idx < in_pos && history[idx % HIST_DEPTH] === lab;
   endfunction

   function void release_voxel();
      longint             q;
      longint             plane;
      longint             total;
      longint             px;
      longint             py;
      longint             pz;
      logic [VOXEL_W-1:0] lab;
      logic [VOXEL_W-1:0] res;
      q     = out_pos;
      plane = dim_x * dim_y;
      total = plane * dim_z;
      lab   = history[q % HIST_DEPTH];
      px    = q % dim_x;
      py    = (q / dim_x) % dim_y;
      pz    = q / plane;
      res   = lab;
      if (lab != '0 && px >= 1 && px + 1 < dim_x && py >= 1 && py + 1 < dim_y &&
          pz >= 1 && pz + 1 < dim_z) begin
         if (holds(q + 1, lab) && holds(q - 1, lab) && holds(q + dim_x, lab) &&
             holds(q - dim_x, lab) && holds(q + plane, lab) && holds(q - plane, lab)) begin
            res = '0;
         end
      end
      want_label.push_back(res);
      want_last.push_back(q + 1 >= total);
      out_pos = q + 1;
      if (out_pos >= total) begin
         in_pos  = 0;
         out_pos = 0;
      end
   endfunction

   function void note_word(logic op, logic [VOXEL_W-1:0] lab);
      longint total;
      total = dim_x * dim_y * dim_z;
      if (op == OP_PUSH) begin
         if (in_pos >= total) begin
            return;
         end
         // The oldest voxel leaves before its slot can be reused.
         if (in_pos + 1 - out_pos > dim_x * dim_y + dim_x) begin
            release_voxel();
         end
         history[in_pos % HIST_DEPTH] = lab & LABEL_MASK;
         in_pos++;
         words_used++;
      end else if (out_pos < in_pos) begin
         release_voxel();
         words_used++;
      end
   endfunction

   function void check_word(logic [VOXEL_W-1:0] lab, logic last);
      logic [VOXEL_W-1:0] e_lab;
      logic               e_last;
      results_seen++;
      if (want_label.size() == 0) begin
         errors++;
         if (errors <= 10) begin
            $display("word %0d unexpected: label %h last %b", results_seen, lab, last);
         end
         return;
      end
      e_lab  = want_label.pop_front();
      e_last = want_last.pop_front();
      if (lab !== e_lab || last !== e_last) begin
         errors++;
         if (errors <= 10) begin
            $display("word %0d mismatch: label exp %h got %h, last exp %b got %b",
                     results_seen, e_lab, lab, e_last, last);
         end
      end
   endfunction
endclass

module label_interior_voxel_clear_3d_tb;

   localparam int CYCLE_LIMIT = 400_000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_opcode = OP_PUSH;
   logic [VOXEL_W-1:0]    req_voxel_label = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VOXEL_W-1:0]    rsp_label_out;
   logic                  rsp_last_voxel;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_SIZE_X;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   voxel_scoreboard sb;
   int              send_idle_pct = 0;
   int              rsp_stall_pct = 0;
   int              hold_left = 0;
   int              cycle_count = 0;

   label_interior_voxel_clear_3d u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_voxel_label (req_voxel_label),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_label_out   (rsp_label_out),
      .rsp_last_voxel  (rsp_last_voxel),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wr_data     (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // A long hold-off, when requested, overrides the random stalls.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         sb.check_word(rsp_label_out, rsp_last_voxel);
      end
   end

   // Entered and left at a falling edge; valid stays high between back-to-back words.
   task automatic send_word(input logic op, input logic [VOXEL_W-1:0] lab);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_voxel_label <= lab;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_word(op, lab);
      @(negedge clock);
   endtask

   // Leaves the write enable high so that writes can follow back to back.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] raw_x, raw_y, raw_z);
      write_csr(REG_SIZE_X, raw_x);
      write_csr(REG_SIZE_Y, raw_y);
      write_csr(REG_SIZE_Z, raw_z);
      csr_wr_en <= 1'b0;
   endtask

   // Wait for every predicted word, then give the pipeline time to empty.
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.want_label.size() != 0) begin
         @(negedge clock);
      end
      repeat (8) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] odd_size(input int top_val);
      case ($urandom_range(2))
         0: return '0;
         1: return CSR_DATA_W'(top_val);
         default: return CSR_DATA_W'($urandom_range(top_val + 1, 16'hFFFF));
      endcase
   endfunction

   task automatic run_volume(input bit hold);
      logic [CSR_DATA_W-1:0] raw_x;
      logic [CSR_DATA_W-1:0] raw_y;
      logic [CSR_DATA_W-1:0] raw_z;
      logic [VOXEL_W-1:0]    palette [4];
      logic [VOXEL_W-1:0]    lab;
      int                    kind;
      int                    style;
      longint                cut_x;
      longint                cut_z;
      longint                total;
      longint                n_push;
      bit                    broken;
      kind   = hold ? 15 : $urandom_range(15);
      broken = hold ? 1'b0 : ($urandom_range(5) == 0);
      raw_x  = ($urandom_range(3) == 0) ? CSR_DATA_W'($urandom_range(1, 2)) :
                                          CSR_DATA_W'($urandom_range(3, 5));
      raw_y  = ($urandom_range(3) == 0) ? CSR_DATA_W'($urandom_range(1, 2)) :
                                          CSR_DATA_W'($urandom_range(3, 5));
      raw_z  = ($urandom_range(3) == 0) ? CSR_DATA_W'($urandom_range(1, 2)) :
                                          CSR_DATA_W'($urandom_range(3, 5));
      case (kind)
         0: begin
            raw_x = odd_size(MAX_X);
            raw_y = CSR_DATA_W'($urandom_range(1, 2));
            raw_z = CSR_DATA_W'($urandom_range(1, 2));
         end
         1: begin
            raw_x = CSR_DATA_W'($urandom_range(1, 3));
            raw_y = odd_size(MAX_Y);
            raw_z = CSR_DATA_W'($urandom_range(1, 2));
         end
         2: begin
            case ($urandom_range(2))
               0: raw_z = '0;
               1: raw_z = 16'hFFFF;
               default: raw_z = CSR_DATA_W'($urandom);
            endcase
         end
         default: ;
      endcase
      // The long hold-off needs enough drains behind it to back up the block.
      if (hold) begin
         raw_x = CSR_DATA_W'($urandom_range(3, 5));
         raw_y = CSR_DATA_W'($urandom_range(3, 5));
         raw_z = CSR_DATA_W'($urandom_range(3, 5));
      end
      configure(raw_x, raw_y, raw_z);
      total = sb.dim_x * sb.dim_y * sb.dim_z;
      // Long rows or deep stacks are only fed in part and then abandoned.
      if (total > 150) begin
         broken = 1'b1;
      end
      if (total < 2) begin
         broken = 1'b0;
      end
      n_push = broken ?
               longint'($urandom_range(1, int'((total - 1 < 80) ? total - 1 : 80))) :
               total;

      style      = $urandom_range(3);
      palette[0] = VOXEL_W'($urandom_range(1, 16'hFFFF));
      for (int i = 1; i < 4; i++) begin
         palette[i] = ($urandom_range(3) == 0) ? '0 : VOXEL_W'($urandom);
      end
      cut_x = $urandom_range(0, int'(sb.dim_x));
      cut_z = $urandom_range(0, int'(sb.dim_z));

      for (longint p = 0; p < n_push; p++) begin
         case (style)
            0: lab = palette[0];
            1: lab = palette[{(p / (sb.dim_x * sb.dim_y)) >= cut_z, (p % sb.dim_x) >= cut_x}];
            2: lab = VOXEL_W'($urandom);
            default: lab = ($urandom_range(5) == 0) ? palette[2'($urandom_range(3))] :
                                                      palette[0];
         endcase
         send_word(OP_PUSH, lab);
         if ($urandom_range(39) == 0) begin
            send_word(OP_DRAIN, VOXEL_W'($urandom));
         end
      end

      if (hold) begin
         hold_left = 300;
      end
      if (broken) begin
         repeat ($urandom_range(0, 4)) send_word(OP_DRAIN, VOXEL_W'($urandom));
      end else begin
         // Whole volume received: drain it, with the odd push that must be ignored.
         while (sb.in_pos != 0) begin
            if ($urandom_range(15) == 0) begin
               send_word(OP_PUSH, VOXEL_W'($urandom));
            end else begin
               send_word(OP_DRAIN, VOXEL_W'($urandom));
            end
         end
         if ($urandom_range(3) == 0) begin
            send_word(OP_DRAIN, VOXEL_W'($urandom));
         end
      end
      settle();
   endtask

   task automatic run_phase(input int s_pct, input int r_pct, input int words,
                            input bit hold);
      int goal;
      send_idle_pct = s_pct;
      rsp_stall_pct = r_pct;
      goal          = sb.words_used + words;
      run_volume(hold);
      while (sb.words_used < goal) begin
         run_volume(1'b0);
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // A 1 x 2 x 2 volume: size_x masks to zero and counts as one row voxel.
      configure(16'hFE00, 16'd2, 16'd2);
      send_word(OP_PUSH, 16'hFFFF);
      send_word(OP_PUSH, 16'h0000);
      send_word(OP_PUSH, 16'h8001);
      send_word(OP_PUSH, 16'h7FFE);
      send_word(OP_PUSH, 16'h1234);
      repeat (3) send_word(OP_DRAIN, 16'h5A5A);
      send_word(OP_DRAIN, 16'hA5A5);
      settle();

      // Widest rows and the deepest stack, fed in part and drained early.
      configure(16'hFFFF, 16'd1, 16'hFFFF);
      send_word(OP_PUSH, 16'h00FF);
      send_word(OP_PUSH, 16'hFF00);
      send_word(OP_PUSH, 16'h0001);
      repeat (4) send_word(OP_DRAIN, 16'hFFFF);
      settle();

      // A write to the spare index must leave the volume in progress alone.
      write_csr(REG_UNUSED, 16'hFFFF);
      csr_wr_en <= 1'b0;
      send_word(OP_PUSH, 16'h4321);
      send_word(OP_PUSH, 16'hC0DE);
      repeat (2) send_word(OP_DRAIN, 16'h0000);
      settle();

      run_phase(0, 0, 245, 1'b1);
      run_phase(87, 0, 245, 1'b0);
      run_phase(0, 87, 245, 1'b0);
      run_phase(31, 31, 245, 1'b0);

      send_idle_pct = 0;
      rsp_stall_pct = 0;
      settle();
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
